@@ rtl/tam_pkg.sv @@
// Shared types and field widths for the three-axis moving average.
package tam_pkg;

    // Width of one sample or one mean on each axis.
    localparam int SAMPLE_W = 16;

    // Number of axes carried per transfer.
    localparam int AXES = 3;

    // One three-axis gyro sample.
    typedef struct packed {
        logic signed [SAMPLE_W-1:0] sample_x;
        logic signed [SAMPLE_W-1:0] sample_y;
        logic signed [SAMPLE_W-1:0] sample_z;
    } t_sample;

    // One three-axis windowed mean.
    typedef struct packed {
        logic signed [SAMPLE_W-1:0] mean_x;
        logic signed [SAMPLE_W-1:0] mean_y;
        logic signed [SAMPLE_W-1:0] mean_z;
    } t_mean;

endpackage

@@ rtl/three_axis_moving_average.sv @@
// Top level of the three-axis boxcar moving average over a ring memory of samples.
// A sample is registered, added into the running sums and then passes the divider stages.
// Throughput: one sample per cycle unless the output is held; ring reads and writes share
// an address within the same cycle, so successive samples never wait on each other.
// Reset: synchronous, active low; clears the pointer, the running sums, the pipeline
// valid flags and one valid bit per ring entry, so unwritten entries read as zero.
module three_axis_moving_average #(
    parameter int WINDOW = 25
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_stall,
    input  tam_pkg::t_sample i_in_data,
    output logic             o_out_valid,
    input  logic             i_out_stall,
    output tam_pkg::t_mean   o_out_data
);

    localparam int PTR_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;
    localparam int SUM_W = $clog2(WINDOW) + tam_pkg::SAMPLE_W;

    logic                     en;
    logic                     accept;
    logic [PTR_W-1:0]         r_ptr;
    logic [PTR_W-1:0]         n_ptr;
    tam_pkg::t_sample         r_hist [WINDOW];
    logic [WINDOW-1:0]        r_hvld;
    logic                     r_s1_vld;
    tam_pkg::t_sample         r_s1_new;
    tam_pkg::t_sample         r_s1_old;
    logic                     r_s1_oldok;
    tam_pkg::t_sample         old_smp;
    logic                     r_s2_vld;
    logic                     r_s3_vld;
    logic signed [SUM_W-1:0]  r_sum [tam_pkg::AXES];
    logic signed [SUM_W-1:0]  n_sum [tam_pkg::AXES];
    logic signed [tam_pkg::SAMPLE_W-1:0] new_ax [tam_pkg::AXES];
    logic signed [tam_pkg::SAMPLE_W-1:0] old_ax [tam_pkg::AXES];
    logic signed [tam_pkg::SAMPLE_W-1:0] mean_ax [tam_pkg::AXES];

    // The whole pipeline moves together unless a finished result is held up.
    assign en         = !(o_out_valid && i_out_stall);
    assign o_in_stall = !en;
    assign accept     = i_in_valid && en;

    // Ring pointer wraps at the window length.
    assign n_ptr = (r_ptr == PTR_W'(WINDOW - 1)) ? '0 : r_ptr + PTR_W'(1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ptr  <= '0;
            r_hvld <= '0;
        end else if (accept) begin
            r_ptr         <= n_ptr;
            r_hvld[r_ptr] <= 1'b1;
        end
    end

    // Ring memory: read the oldest sample and overwrite it with the new one.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_old      <= r_hist[r_ptr];
            r_hist[r_ptr] <= i_in_data;
            r_s1_oldok    <= r_hvld[r_ptr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s1_new <= i_in_data;
        end
    end

    // An entry never written since reset counts as zero.
    assign old_smp = r_s1_oldok ? r_s1_old : '0;

    assign new_ax[0] = r_s1_new.sample_x;
    assign new_ax[1] = r_s1_new.sample_y;
    assign new_ax[2] = r_s1_new.sample_z;
    assign old_ax[0] = old_smp.sample_x;
    assign old_ax[1] = old_smp.sample_y;
    assign old_ax[2] = old_smp.sample_z;

    // Running sums: add the new sample, remove the one it replaced.
    always_comb begin
        for (int a = 0; a < tam_pkg::AXES; a++) begin
            n_sum[a] = r_sum[a] + SUM_W'(new_ax[a]) - SUM_W'(old_ax[a]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int a = 0; a < tam_pkg::AXES; a++) begin
                r_sum[a] <= '0;
            end
        end else if (en && r_s1_vld) begin
            for (int a = 0; a < tam_pkg::AXES; a++) begin
                r_sum[a] <= n_sum[a];
            end
        end
    end

    // Pipeline valid flags.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld    <= 1'b0;
            r_s2_vld    <= 1'b0;
            r_s3_vld    <= 1'b0;
            o_out_valid <= 1'b0;
        end else if (en) begin
            r_s1_vld    <= i_in_valid;
            r_s2_vld    <= r_s1_vld;
            r_s3_vld    <= r_s2_vld;
            o_out_valid <= r_s3_vld;
        end
    end

    // Division by the window length, one unit per axis.
    for (genvar g = 0; g < tam_pkg::AXES; g++) begin : g_div
        tam_div #(
            .WINDOW (WINDOW),
            .SUM_W  (SUM_W)
        ) u_div (
            .i_clk  (i_clk),
            .i_en   (en),
            .i_sum  (r_sum[g]),
            .o_mean (mean_ax[g])
        );
    end

    assign o_out_data.mean_x = mean_ax[0];
    assign o_out_data.mean_y = mean_ax[1];
    assign o_out_data.mean_z = mean_ax[2];

    // The ring pointer always names a slot inside the window.
    a_ptr_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ptr <= PTR_W'(WINDOW - 1))
        else $error("ring pointer outside the window");

    // A held result stops new transfers on the input side.
    a_stall_back: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |-> o_in_stall)
        else $error("input accepted while the output is held");

    // An accepted sample enters the first stage and advances the pointer.
    a_accept_s1: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> (r_s1_vld && r_ptr != $past(r_ptr)))
        else $error("accepted sample lost at the first stage");

    // Sums change only when a sample leaves the first stage.
    a_sum_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(r_s1_vld && en) |=> (r_sum[0] == $past(r_sum[0])
                               && r_sum[1] == $past(r_sum[1])
                               && r_sum[2] == $past(r_sum[2])))
        else $error("running sum changed without a sample");

endmodule

@@ rtl/tam_div.sv @@
// Two-stage division of a signed running sum by the window length, truncating toward zero.
module tam_div #(
    parameter int WINDOW = 25,
    parameter int SUM_W  = 21
) (
    input  logic                              i_clk,
    input  logic                              i_en,
    input  logic signed [SUM_W-1:0]           i_sum,
    output logic signed [tam_pkg::SAMPLE_W-1:0] o_mean
);

    // Reciprocal with three guard bits, so the estimate is low by at most one.
    localparam int K      = SUM_W + 3;
    localparam int PROD_W = SUM_W + K;
    localparam int Q_W    = tam_pkg::SAMPLE_W + 1;
    localparam logic [K-1:0] RECIP = K'((64'd1 << K) / WINDOW);

    logic [SUM_W-1:0]  n_abs;
    logic [SUM_W-1:0]  r_abs;
    logic              r_neg;
    logic [PROD_W-1:0] r_prod;
    logic [Q_W-1:0]    q_est;
    logic [SUM_W-1:0]  q_times_w;
    logic [SUM_W-1:0]  rem;
    logic [Q_W-1:0]    q_fix;
    logic [Q_W-1:0]    q_signed;

    // Magnitude of the sum; the most negative value maps onto its unsigned magnitude.
    assign n_abs = i_sum[SUM_W-1] ? SUM_W'(-i_sum) : SUM_W'(i_sum);

    // First stage: magnitude times reciprocal.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_abs  <= n_abs;
            r_neg  <= i_sum[SUM_W-1];
            r_prod <= PROD_W'(n_abs) * PROD_W'(RECIP);
        end
    end

    // Correct the estimate by one where the remainder still reaches the window length.
    always_comb begin
        q_est     = r_prod[K +: Q_W];
        q_times_w = SUM_W'(q_est) * SUM_W'(WINDOW);
        rem       = r_abs - q_times_w;
        q_fix     = (rem >= SUM_W'(WINDOW)) ? q_est + Q_W'(1) : q_est;
        q_signed  = r_neg ? Q_W'(-q_fix) : q_fix;
    end

    // Second stage: signed quotient.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_mean <= q_signed[tam_pkg::SAMPLE_W-1:0];
        end
    end

endmodule
